// ===== sv/pfl_pkg.sv =====
// Shared widths, codes and types of the paged free-list allocator.
package pfl_pkg;

    localparam int MAX_SLOTS = 4096;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int USED_W    = SLOT_W + 1;
    localparam int ADDR_W    = 24;
    localparam int CMD_W     = 2;

    localparam int ITEM_W    = 4;
    localparam int PAGE_W    = 5;
    localparam int CAP_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam int ITEM_MIN  = 3;
    localparam int ITEM_MAX  = 12;
    localparam int PAGE_MIN  = 12;
    localparam int PAGE_MAX  = 16;
    localparam int CAP_RST   = 128;

    localparam int BLK_W     = PAGE_MAX - ITEM_MIN + 1;
    localparam int D_W       = $clog2(PAGE_MAX - ITEM_MIN + 1);
    localparam int SUM_W     = (USED_W > BLK_W ? USED_W : BLK_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_INIT  = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_ITEM_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP  = 2'd2;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } t_link;

endpackage

// ===== sv/pfl_if.sv =====
// Request and result channel interfaces of the paged free-list allocator.
interface pfl_cmd_if import pfl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, output command, output block_address, input ready);
    modport sink (input valid, input command, input block_address, output ready);
endinterface

interface pfl_res_if import pfl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_address;
    logic              status;

    modport source (output valid, output result_address, output status, input ready);
    modport sink (input valid, input result_address, input status, output ready);
endinterface

// ===== sv/paged_free_list_allocator.sv =====
// Paged free-list block allocator: LIFO free list of next links kept in one memory.
//
//   channel   dir   payload                        handshake
//   i_cmd     in    command, block_address         valid/ready
//   o_res     out   result_address, status         valid/ready, one per request
//   i_cfg_*   in    item size, page size, capacity write enable, no read-back
//
// A pop reads the head's link from the link RAM as the request is accepted; that link
// becomes the new head in the pop state once the output is free. Free and failed alloc finish in the exec state.
// Alloc on an empty list writes one link per cycle over a new page.
// Clear and init sweep the link RAM at one slot per cycle over the reserved slots.
// Reset needs no clearing pass; the output register lets a request be accepted while a
// result waits, and the block stalls only where a result must be loaded.
module paged_free_list_allocator import pfl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pfl_cmd_if.sink              i_cmd,
    pfl_res_if.source            o_res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_POP   = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [ITEM_W-1:0]   r_cfg_item;
    logic [PAGE_W-1:0]   r_cfg_page;
    logic [CAP_W-1:0]    r_cfg_cap;
    logic [ITEM_W-1:0]   r_item, n_item;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic                r_head_ok, n_head_ok;
    logic [USED_W-1:0]   r_used, n_used;
    t_cmd                r_cmd, n_cmd;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [SLOT_W-1:0]   r_sw, n_sw;
    logic [SLOT_W-1:0]   r_sw_last, n_sw_last;
    logic                r_sw_init, n_sw_init;
    logic [ADDR_W-1:0]   r_pend_addr, n_pend_addr;
    logic                r_oval, n_oval;
    logic [ADDR_W-1:0]   r_oaddr, n_oaddr;
    logic                r_ostat, n_ostat;

    t_link               r_mem [MAX_SLOTS];
    t_link               r_rd;
    logic                w_we;
    logic [SLOT_W-1:0]   w_wa;
    t_link               w_wd;

    logic                out_free;
    logic [D_W-1:0]      cur_d, new_d;
    logic [BLK_W-1:0]    blk, new_blk;
    logic                fits;
    logic [ITEM_W-1:0]   cl_item;
    logic [PAGE_W-1:0]   cl_page;
    logic [SUM_W-1:0]    cap_pages, init_lim, init_n;
    logic [ADDR_W-1:0]   free_slot;
    logic                free_ok;
    logic                sw_page_end, sw_page_nz;
    logic [SUM_W-1:0]    sw_prev;
    t_link               sw_link;

    assign out_free    = !r_oval || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);

    assign o_res.valid          = r_oval;
    assign o_res.result_address = r_oaddr;
    assign o_res.status         = r_ostat;

    // Geometry in use and geometry that an init would latch.
    assign cur_d = D_W'(r_page - PAGE_W'(r_item));
    assign blk   = BLK_W'(1) << cur_d;
    assign fits  = (SUM_W'(r_used) + SUM_W'(blk)) <= SUM_W'(MAX_SLOTS);

    assign cl_item = (r_cfg_item < ITEM_W'(ITEM_MIN)) ? ITEM_W'(ITEM_MIN) :
                     (r_cfg_item > ITEM_W'(ITEM_MAX)) ? ITEM_W'(ITEM_MAX) : r_cfg_item;
    assign cl_page = (r_cfg_page < PAGE_W'(PAGE_MIN)) ? PAGE_W'(PAGE_MIN) :
                     (r_cfg_page > PAGE_W'(PAGE_MAX)) ? PAGE_W'(PAGE_MAX) : r_cfg_page;
    assign new_d   = D_W'(cl_page - PAGE_W'(cl_item));
    assign new_blk = BLK_W'(1) << new_d;

    // Whole pages from the capacity, limited to the whole pages that fit in the pool.
    assign cap_pages = SUM_W'(r_cfg_cap) & ~SUM_W'(new_blk - BLK_W'(1));
    assign init_lim  = (SUM_W'(new_blk) <= SUM_W'(MAX_SLOTS)) ? SUM_W'(MAX_SLOTS) : '0;
    assign init_n    = (cap_pages < init_lim) ? cap_pages : init_lim;

    assign free_slot = r_addr >> r_item;
    assign free_ok   = free_slot < ADDR_W'(r_used);

    // During init each page's last block links back to the base of the page before it.
    assign sw_page_end = ((BLK_W'(r_sw) & (blk - BLK_W'(1))) == (blk - BLK_W'(1)));
    assign sw_page_nz  = SUM_W'(r_sw) >= SUM_W'(blk);
    assign sw_prev     = SUM_W'(r_sw) + SUM_W'(1) - (SUM_W'(blk) << 1);

    always_comb begin
        if (r_sw_init && sw_page_end) begin
            sw_link.ok   = sw_page_nz;
            sw_link.slot = sw_page_nz ? SLOT_W'(sw_prev) : '0;
        end else if (!r_sw_init && r_sw == r_sw_last) begin
            sw_link.ok   = 1'b0;
            sw_link.slot = '0;
        end else begin
            sw_link.ok   = 1'b1;
            sw_link.slot = r_sw + SLOT_W'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_page      = r_page;
        n_head      = r_head;
        n_head_ok   = r_head_ok;
        n_used      = r_used;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_sw        = r_sw;
        n_sw_last   = r_sw_last;
        n_sw_init   = r_sw_init;
        n_pend_addr = r_pend_addr;
        n_oval      = r_oval && !o_res.ready;
        n_oaddr     = r_oaddr;
        n_ostat     = r_ostat;
        w_we        = 1'b0;
        w_wa        = sw_link.slot;
        w_wd        = sw_link;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd  = t_cmd'(i_cmd.command);
                    n_addr = i_cmd.block_address;
                    if (t_cmd'(i_cmd.command) == CMD_ALLOC && r_head_ok) begin
                        n_state = ST_POP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_POP: begin
                if (out_free) begin
                    n_oval    = 1'b1;
                    n_oaddr   = ADDR_W'(r_head) << r_item;
                    n_ostat   = 1'b0;
                    n_head    = r_rd.slot;
                    n_head_ok = r_rd.ok;
                    n_state   = ST_IDLE;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_pend_addr = '0;
                    n_oaddr     = '0;
                    n_ostat     = 1'b0;
                    unique case (r_cmd)
                        CMD_ALLOC: begin
                            if (fits) begin
                                n_used      = USED_W'(SUM_W'(r_used) + SUM_W'(blk));
                                n_sw        = SLOT_W'(r_used);
                                n_sw_last   = SLOT_W'(SUM_W'(r_used) + SUM_W'(blk)
                                                      - SUM_W'(1));
                                n_sw_init   = 1'b0;
                                n_head      = SLOT_W'(r_used) + SLOT_W'(1);
                                n_head_ok   = (blk != BLK_W'(1));
                                n_pend_addr = ADDR_W'(r_used) << r_item;
                                n_state     = ST_SWEEP;
                            end else begin
                                n_oval  = 1'b1;
                                n_ostat = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                        CMD_FREE: begin
                            if (free_ok) begin
                                w_we      = 1'b1;
                                w_wa      = SLOT_W'(free_slot);
                                w_wd.ok   = r_head_ok;
                                w_wd.slot = r_head_ok ? r_head : '0;
                                n_head    = SLOT_W'(free_slot);
                                n_head_ok = 1'b1;
                            end
                            n_oval  = 1'b1;
                            n_state = ST_IDLE;
                        end
                        CMD_CLEAR: begin
                            if (r_used != '0) begin
                                n_sw      = '0;
                                n_sw_last = SLOT_W'(r_used - USED_W'(1));
                                n_sw_init = 1'b0;
                                n_head    = '0;
                                n_head_ok = 1'b1;
                                n_state   = ST_SWEEP;
                            end else begin
                                n_oval  = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                        CMD_INIT: begin
                            n_item    = cl_item;
                            n_page    = cl_page;
                            n_used    = USED_W'(init_n);
                            n_head    = SLOT_W'(init_n - SUM_W'(new_blk));
                            n_head_ok = (init_n != '0);
                            n_sw      = '0;
                            n_sw_last = SLOT_W'(init_n - SUM_W'(1));
                            n_sw_init = 1'b1;
                            if (init_n != '0) begin
                                n_state = ST_SWEEP;
                            end else begin
                                n_oval  = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                w_we = 1'b1;
                w_wa = r_sw;
                w_wd = sw_link;
                if (r_sw == r_sw_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_sw = r_sw + SLOT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_oaddr = r_pend_addr;
                    n_ostat = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Link RAM: the head's link is read every idle cycle so a pop needs no extra wait.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (r_state == ST_IDLE) begin
            r_rd <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cfg_item <= ITEM_W'(ITEM_MIN);
            r_cfg_page <= PAGE_W'(PAGE_MIN);
            r_cfg_cap  <= CAP_W'(CAP_RST);
            r_item     <= ITEM_W'(ITEM_MIN);
            r_page     <= PAGE_W'(PAGE_MIN);
            r_head     <= '0;
            r_head_ok  <= 1'b0;
            r_used     <= '0;
            r_oval     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_item    <= n_item;
            r_page    <= n_page;
            r_head    <= n_head;
            r_head_ok <= n_head_ok;
            r_used    <= n_used;
            r_oval    <= n_oval;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ITEM_SIZE: r_cfg_item <= i_cfg_data[ITEM_W-1:0];
                    REG_PAGE_SIZE: r_cfg_page <= i_cfg_data[PAGE_W-1:0];
                    REG_INIT_CAP:  r_cfg_cap  <= i_cfg_data[CAP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_addr      <= n_addr;
        r_sw        <= n_sw;
        r_sw_last   <= n_sw_last;
        r_sw_init   <= n_sw_init;
        r_pend_addr <= n_pend_addr;
        r_oaddr     <= n_oaddr;
        r_ostat     <= n_ostat;
    end

`ifndef SYNTH
    // The sweep never writes a link outside the reserved slots.
    a_sweep_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (USED_W'(r_sw) < r_used))
        else $error("sweep slot outside the reserved pages");

    // A valid head always points into the reserved slots.
    a_head_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_ok |-> (USED_W'(r_head) < r_used))
        else $error("list head outside the reserved pages");

    // An out-of-memory result never carries an address.
    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_ostat) |-> (r_oaddr == '0))
        else $error("out-of-memory result with nonzero address");

    // A pop with the output free delivers its result in the cycle after its pop state.
    a_pop_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP && out_free) |=> (r_oval && r_state == ST_IDLE))
        else $error("pop result not loaded");
`endif

endmodule
